// ===== src/rau_pkg.sv =====
`default_nettype none

package rau_pkg;

    // Default internal word width of the arithmetic.
    localparam int DEFAULT_WORD_WIDTH = 32;

    // Fixed field widths of the stream payloads.
    localparam int OP_W        = 3;
    localparam int FIELD_W     = 32;
    localparam int DEN_W       = 31;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 72;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_NORM = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_LESS = 3'd5;
    localparam logic [OP_W-1:0] OP_EQ   = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE = 3'd7;

    // Which fraction a reduction pass works on.
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_R = 2'd2;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RINIT = 4'd1;
    localparam logic [3:0] S_GCD   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_RFIN  = 4'd4;
    localparam logic [3:0] S_MSET  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MFIN  = 4'd7;
    localparam logic [3:0] S_COMB  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

endpackage

`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
`default_nettype none

// Rational arithmetic unit: takes an operation code and two fractions A and B, brings
// both to lowest terms, and returns either a reduced fraction (normalise A, add,
// subtract, multiply, divide) or a comparison (less, equal). Arithmetic runs on
// WORD_WIDTH-bit two's complement words; every wrap of a product, sum, difference or
// sign flip sets overflow. One item is in flight at a time; s_axis_tready is high only
// while the sequencer is idle. The work runs through bit-serial add/subtract-and-shift
// steps: a reduction is a binary gcd, then a divider pass over the numerator and one
// over the denominator by the gcd; a cross product is a shift-and-add multiply. An
// add or subtract item runs three reductions and three products; an unused code skips
// them. A finished result waits in the output register, so a new transaction is taken
// while the previous result is still unread.
module rational_arithmetic_unit #(
    parameter int WORD_WIDTH = rau_pkg::DEFAULT_WORD_WIDTH
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_type[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero fill
    input  wire  [rau_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // res_num[31:0], res_den[62:32], cmp_true[63], zero_den[64], overflow[65], zero fill
    output logic [rau_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int W  = WORD_WIDTH;
    localparam int KW = $clog2(W);
    localparam int FW = rau_pkg::FIELD_W;
    localparam int DW = rau_pkg::DEN_W;
    localparam int OW = rau_pkg::OP_W;

    // control
    logic [3:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [1:0]    midx_reg, midx_next;
    logic          pass_reg, pass_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;

    // payload
    logic [OW-1:0] op_reg, op_next;
    logic [W-1:0]  in_an_reg, in_an_next, in_ad_reg, in_ad_next;
    logic [W-1:0]  in_bn_reg, in_bn_next, in_bd_reg, in_bd_next;
    logic [W-1:0]  a_n_reg, a_n_next, a_d_reg, a_d_next;
    logic [W-1:0]  b_n_reg, b_n_next, b_d_reg, b_d_next;
    logic [W-1:0]  p1_reg, p1_next, p2_reg, p2_next, p3_reg, p3_next;
    logic [W-1:0]  sum_reg, sum_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  mn_reg, mn_next, md_reg, md_next;
    logic [W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  g_reg, g_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rn_reg, rn_next;
    logic [W-1:0]  ma_reg, ma_next;
    logic [2*W-1:0] prod_reg, prod_next;
    logic          mneg_reg, mneg_next;
    logic          ov_reg, ov_next;
    logic          cmp_reg, cmp_next;
    logic          isfrac_reg, isfrac_next;
    logic [W-1:0]  rnum_reg, rnum_next, rden_reg, rden_next;
    logic [rau_pkg::OUT_TDATA_W-1:0] out_reg, out_next;

    // datapath temporaries
    logic [W-1:0]  sel_n, sel_d, fl_n, fl_d;
    logic [W-1:0]  mx, my, m_lo, m_res;
    logic [W:0]    rem_sh, diff, mul_sum;
    logic [W-1:0]  quo_sh, rn_signed, cmb;
    logic          div_bit, mul_need, mul_ov;
    logic [W-1:0]  w_min;

    assign w_min = {1'b1, {(W-1){1'b0}}};

    assign s_axis_tready = (state_reg == rau_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        // reduction operands by pass
        unique case (phase_reg)
            rau_pkg::PH_A: begin sel_n = in_an_reg; sel_d = in_ad_reg; end
            rau_pkg::PH_B: begin sel_n = in_bn_reg; sel_d = in_bd_reg; end
            default:       begin sel_n = sum_reg;   sel_d = p3_reg;    end
        endcase
        fl_n = sel_d[W-1] ? W'(-sel_n) : sel_n;
        fl_d = sel_d[W-1] ? W'(-sel_d) : sel_d;

        // divider step
        rem_sh  = {rem_reg[W-1:0], dvd_reg[W-1]};
        diff    = rem_sh - {1'b0, g_reg};
        div_bit = !diff[W];
        quo_sh  = {quo_reg[W-2:0], div_bit};

        // product operand selection and slot use
        unique case (midx_reg)
            2'd0:    begin
                         mx = a_n_reg;
                         my = (op_reg == rau_pkg::OP_MUL) ? b_n_reg : b_d_reg;
                         mul_need = 1'b1;
                     end
            2'd1:    begin
                         mx = b_n_reg; my = a_d_reg;
                         mul_need = (op_reg == rau_pkg::OP_ADD) || (op_reg == rau_pkg::OP_SUB)
                                 || (op_reg == rau_pkg::OP_LESS);
                     end
            2'd2:    begin
                         mx = a_d_reg;
                         my = (op_reg == rau_pkg::OP_DIV) ? b_n_reg : b_d_reg;
                         mul_need = (op_reg != rau_pkg::OP_LESS);
                     end
            default: begin mx = a_n_reg; my = b_d_reg; mul_need = 1'b0; end
        endcase

        // multiplier step: add the multiplicand into the high half, shift right
        mul_sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, ma_reg} : '0);

        // product finish: wrap test on the full magnitude
        m_lo   = prod_reg[W-1:0];
        m_res  = mneg_reg ? W'(-m_lo) : m_lo;
        mul_ov = mneg_reg ? ((|prod_reg[2*W-1:W]) || (prod_reg[W-1] && (|prod_reg[W-2:0])))
                          : (|prod_reg[2*W-1:W-1]);

        rn_signed = neg_reg ? W'(-rn_reg) : rn_reg;
        cmb = (op_reg == rau_pkg::OP_SUB) ? W'(p1_reg - p2_reg) : W'(p1_reg + p2_reg);

        // defaults: hold
        state_next = state_reg;   phase_next = phase_reg; midx_next = midx_reg;
        pass_next = pass_reg;     cnt_next = cnt_reg;     m_valid_next = m_valid_reg;
        op_next = op_reg;
        in_an_next = in_an_reg;   in_ad_next = in_ad_reg;
        in_bn_next = in_bn_reg;   in_bd_next = in_bd_reg;
        a_n_next = a_n_reg;       a_d_next = a_d_reg;
        b_n_next = b_n_reg;       b_d_next = b_d_reg;
        p1_next = p1_reg;         p2_next = p2_reg;       p3_next = p3_reg;
        sum_next = sum_reg;       neg_next = neg_reg;
        mn_next = mn_reg;         md_next = md_reg;
        x_next = x_reg;           y_next = y_reg;         k_next = k_reg;
        g_next = g_reg;           dvd_next = dvd_reg;     rem_next = rem_reg;
        quo_next = quo_reg;       rn_next = rn_reg;
        ma_next = ma_reg;         prod_next = prod_reg;   mneg_next = mneg_reg;
        ov_next = ov_reg;         cmp_next = cmp_reg;     isfrac_next = isfrac_reg;
        rnum_next = rnum_reg;     rden_next = rden_reg;   out_next = out_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            rau_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tdata[2:0];
                    in_an_next = W'(signed'(s_axis_tdata[34:3]));
                    in_ad_next = W'(signed'(s_axis_tdata[66:35]));
                    in_bn_next = W'(signed'(s_axis_tdata[98:67]));
                    in_bd_next = W'(signed'(s_axis_tdata[130:99]));
                    ov_next     = 1'b0;
                    cmp_next    = 1'b0;
                    isfrac_next = 1'b0;
                    rnum_next   = '0;
                    rden_next   = W'(1);
                    phase_next  = rau_pkg::PH_A;
                    state_next  = (s_axis_tdata[2:0] == rau_pkg::OP_NONE) ? rau_pkg::S_DONE
                                                                         : rau_pkg::S_RINIT;
                end
            end
            rau_pkg::S_RINIT:
            begin
                rem_next = '0;
                if (sel_n == '0)
                begin
                    // zero numerator: straight to 0/1
                    neg_next   = 1'b0;
                    rn_next    = '0;
                    quo_next   = W'(1);
                    state_next = rau_pkg::S_RFIN;
                end
                else
                begin
                    if (sel_d[W-1] && ((sel_n == w_min) || (sel_d == w_min)))
                        ov_next = 1'b1;
                    neg_next   = fl_n[W-1];
                    mn_next    = fl_n[W-1] ? W'(-fl_n) : fl_n;
                    md_next    = fl_d[W-1] ? W'(-fl_d) : fl_d;
                    x_next     = fl_n[W-1] ? W'(-fl_n) : fl_n;
                    y_next     = fl_d[W-1] ? W'(-fl_d) : fl_d;
                    k_next     = '0;
                    state_next = rau_pkg::S_GCD;
                end
            end
            rau_pkg::S_GCD:
            begin
                // binary gcd, one step a cycle
                priority if (y_reg == '0)
                begin
                    g_next     = x_reg << k_reg;
                    dvd_next   = mn_reg;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    pass_next  = 1'b0;
                    state_next = rau_pkg::S_DIV;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!x_reg[0])
                    x_next = x_reg >> 1;
                else if (!y_reg[0])
                    y_next = y_reg >> 1;
                else if (x_reg > y_reg)
                    x_next = x_reg - y_reg;
                else
                    y_next = y_reg - x_reg;
            end
            rau_pkg::S_DIV:
            begin
                rem_next = div_bit ? diff : rem_sh;
                quo_next = quo_sh;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == KW'(W-1))
                begin
                    cnt_next = '0;
                    if (!pass_reg)
                    begin
                        rn_next   = quo_sh;
                        dvd_next  = md_reg;
                        rem_next  = '0;
                        quo_next  = '0;
                        pass_next = 1'b1;
                    end
                    else
                        state_next = rau_pkg::S_RFIN;
                end
            end
            rau_pkg::S_RFIN:
            begin
                if ((!neg_reg && rn_reg[W-1]) || quo_reg[W-1])
                    ov_next = 1'b1;
                rnum_next = rn_signed;
                rden_next = quo_reg;
                unique case (phase_reg)
                    rau_pkg::PH_A:
                    begin
                        a_n_next = rn_signed;
                        a_d_next = quo_reg;
                        if (op_reg == rau_pkg::OP_NORM)
                        begin
                            isfrac_next = 1'b1;
                            state_next  = rau_pkg::S_DONE;
                        end
                        else
                        begin
                            phase_next = rau_pkg::PH_B;
                            state_next = rau_pkg::S_RINIT;
                        end
                    end
                    rau_pkg::PH_B:
                    begin
                        b_n_next = rn_signed;
                        b_d_next = quo_reg;
                        if (op_reg == rau_pkg::OP_EQ)
                        begin
                            cmp_next   = (a_n_reg == rn_signed) && (a_d_reg == quo_reg);
                            state_next = rau_pkg::S_DONE;
                        end
                        else
                        begin
                            midx_next  = 2'd0;
                            state_next = rau_pkg::S_MSET;
                        end
                    end
                    default:
                    begin
                        isfrac_next = 1'b1;
                        state_next  = rau_pkg::S_DONE;
                    end
                endcase
            end
            rau_pkg::S_MSET:
            begin
                priority if (midx_reg == 2'd3)
                    state_next = rau_pkg::S_COMB;
                else if (mul_need)
                begin
                    ma_next    = mx[W-1] ? W'(-mx) : mx;
                    prod_next  = {{W{1'b0}}, (my[W-1] ? W'(-my) : my)};
                    mneg_next  = mx[W-1] ^ my[W-1];
                    cnt_next   = '0;
                    state_next = rau_pkg::S_MUL;
                end
                else
                    midx_next = midx_reg + 2'd1;
            end
            rau_pkg::S_MUL:
            begin
                prod_next = {mul_sum, prod_reg[W-1:1]};
                cnt_next  = cnt_reg + KW'(1);
                if (cnt_reg == KW'(W-1))
                begin
                    cnt_next   = '0;
                    state_next = rau_pkg::S_MFIN;
                end
            end
            rau_pkg::S_MFIN:
            begin
                if (mul_ov)
                    ov_next = 1'b1;
                unique case (midx_reg)
                    2'd0:    p1_next = m_res;
                    2'd1:    p2_next = m_res;
                    default: p3_next = m_res;
                endcase
                midx_next  = midx_reg + 2'd1;
                state_next = rau_pkg::S_MSET;
            end
            rau_pkg::S_COMB:
            begin
                priority if (op_reg == rau_pkg::OP_LESS)
                begin
                    cmp_next   = $signed(p1_reg) < $signed(p2_reg);
                    state_next = rau_pkg::S_DONE;
                end
                else
                begin
                    if (op_reg == rau_pkg::OP_ADD)
                    begin
                        sum_next = cmb;
                        if ((p1_reg[W-1] == p2_reg[W-1]) && (cmb[W-1] != p1_reg[W-1]))
                            ov_next = 1'b1;
                    end
                    else if (op_reg == rau_pkg::OP_SUB)
                    begin
                        sum_next = cmb;
                        if ((p1_reg[W-1] != p2_reg[W-1]) && (cmb[W-1] != p1_reg[W-1]))
                            ov_next = 1'b1;
                    end
                    else
                        sum_next = p1_reg;
                    phase_next = rau_pkg::PH_R;
                    state_next = rau_pkg::S_RINIT;
                end
            end
            rau_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_next = '0;
                    out_next[31:0]  = isfrac_reg ? FW'(signed'(rnum_reg)) : '0;
                    out_next[62:32] = isfrac_reg ? DW'(signed'(rden_reg)) : DW'(1);
                    out_next[63]    = cmp_reg;
                    out_next[64]    = isfrac_reg && (rden_reg == '0);
                    out_next[65]    = ov_reg;
                    m_valid_next    = 1'b1;
                    state_next      = rau_pkg::S_IDLE;
                end
            end
            default:
                state_next = rau_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rau_pkg::S_IDLE;
            phase_reg   <= rau_pkg::PH_A;
            midx_reg    <= 2'd0;
            pass_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            midx_reg    <= midx_next;
            pass_reg    <= pass_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        in_an_reg <= in_an_next;  in_ad_reg <= in_ad_next;
        in_bn_reg <= in_bn_next;  in_bd_reg <= in_bd_next;
        a_n_reg <= a_n_next;      a_d_reg <= a_d_next;
        b_n_reg <= b_n_next;      b_d_reg <= b_d_next;
        p1_reg <= p1_next;        p2_reg <= p2_next;      p3_reg <= p3_next;
        sum_reg <= sum_next;      neg_reg <= neg_next;
        mn_reg <= mn_next;        md_reg <= md_next;
        x_reg <= x_next;          y_reg <= y_next;        k_reg <= k_next;
        g_reg <= g_next;          dvd_reg <= dvd_next;    rem_reg <= rem_next;
        quo_reg <= quo_next;      rn_reg <= rn_next;
        ma_reg <= ma_next;        prod_reg <= prod_next;  mneg_reg <= mneg_next;
        ov_reg <= ov_next;        cmp_reg <= cmp_next;    isfrac_reg <= isfrac_next;
        rnum_reg <= rnum_next;    rden_reg <= rden_next;  out_reg <= out_next;
    end

    // The gcd working value never drops to zero, so the divisor is never zero.
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rau_pkg::S_GCD) |-> (x_reg != '0))
        else $error("gcd operand reached zero");

    // The gcd divides the denominator exactly: no remainder after the second pass.
    a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rau_pkg::S_RFIN) |-> (rem_reg == '0))
        else $error("reduction left a remainder");

    // A comparison result carries the fixed fraction 0/1 and no zero denominator.
    a_cmp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && out_reg[63]) |-> ((out_reg[31:0] == '0) && (out_reg[62:32] == DW'(1))
                                         && !out_reg[64]))
        else $error("comparison result with fraction fields set");

    // Zero denominator flag agrees with the denominator field.
    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && out_reg[64]) |-> (out_reg[62:32] == '0))
        else $error("zero denominator flag with nonzero denominator");

endmodule

`default_nettype wire
